// ===== hw/rtl/wmmf_pkg.sv =====
// wmmf_pkg: shared constants, types and helpers of the 3x3 window filter
// used by the line store, column cell and top level; depends on nothing

`timescale 1ns / 1ps
`default_nettype none

package wmmf_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int HEIGHT_LIMIT = 4096;
    localparam int SIZE_MIN     = 3;
    localparam int WIN          = 3;

    localparam int PIX_W  = 8;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 11;
    localparam int WID_W  = 12;
    localparam int HGT_W  = 13;
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 2;
    localparam int MODE_W = 2;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int COL_SUM_W   = 10;
    localparam int WIN_SUM_W   = 12;
    localparam int RECIP_9     = 7282;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = WIN_SUM_W + 13;

    typedef enum logic [IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_MEAN = 2'd0,
        MODE_MIN  = 2'd1,
        MODE_MAX  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col_pix;

    typedef struct packed {
        logic [COL_SUM_W-1:0] sum;
        logic [PIX_W-1:0]     min_v;
        logic [PIX_W-1:0]     max_v;
    } t_col_stat;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_meta;

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wmmf_line_store.sv =====
// wmmf_line_store: the two previous rows, packed as {older, newer} per column
// single write port, one registered read port; uses wmmf_pkg

`timescale 1ns / 1ps
`default_nettype none

module wmmf_line_store (
    input  wire logic                                i_clk,
    input  wire logic                                i_rd_en,
    input  wire logic [wmmf_pkg::ADDR_W-1:0]         i_rd_addr,
    output logic      [2*wmmf_pkg::PIX_W-1:0]        o_rd_data,
    input  wire logic                                i_wr_en,
    input  wire logic [wmmf_pkg::ADDR_W-1:0]         i_wr_addr,
    input  wire logic [2*wmmf_pkg::PIX_W-1:0]        i_wr_data
);
    import wmmf_pkg::*;

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/wmmf_col_cell.sv =====
// wmmf_col_cell: one column of the 3x3 window, passed on to its neighbor
// gives the column sum, minimum and maximum; uses wmmf_pkg

`timescale 1ns / 1ps
`default_nettype none

module wmmf_col_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire wmmf_pkg::t_col_pix   i_pix,
    output wmmf_pkg::t_col_pix        o_pix,
    output wmmf_pkg::t_col_stat       o_stat
);
    import wmmf_pkg::*;

    t_col_pix r_pix;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= i_pix;
        end
    end

    always_comb begin
        o_stat.sum   = COL_SUM_W'(r_pix.top) + COL_SUM_W'(r_pix.mid) + COL_SUM_W'(r_pix.bot);
        o_stat.min_v = min3(r_pix.top, r_pix.mid, r_pix.bot);
        o_stat.max_v = max3(r_pix.top, r_pix.mid, r_pix.bot);
    end

    assign o_pix = r_pix;

endmodule

`default_nettype wire

// ===== hw/rtl/window_3x3_mean_min_max_filter.sv =====
// window_3x3_mean_min_max_filter: 3x3 mean / min / max filter over a raster stream
// uses wmmf_pkg, wmmf_line_store and wmmf_col_cell
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall    i_pixel
//   output    out        o_out_valid / i_out_stall  o_out_row o_out_col o_value o_last
//   config    in         i_cfg_we                   i_cfg_index i_cfg_data
//
// one pixel per cycle while o_in_stall is low; each result is registered in turn by
// line store read, window shift, window combine, divide and select
// each stage holds its word under stall, so input stalls only when all are full
// reset sets 640 x 480, mean mode and restarts the frame; no clearing pass

`timescale 1ns / 1ps
`default_nettype none

module window_3x3_mean_min_max_filter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [wmmf_pkg::PIX_W-1:0]     i_pixel,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [wmmf_pkg::ROW_W-1:0]     o_out_row,
    output logic      [wmmf_pkg::COL_W-1:0]     o_out_col,
    output logic      [wmmf_pkg::PIX_W-1:0]     o_value,
    output logic                                o_last,
    input  wire logic                           i_cfg_we,
    input  wire logic [wmmf_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [wmmf_pkg::CFG_W-1:0]     i_cfg_data
);
    import wmmf_pkg::*;

    // configuration
    logic [ADDR_W-1:0] r_w_last;
    logic [ROW_W-1:0]  r_h_last;
    logic [MODE_W-1:0] r_mode;
    logic [ADDR_W-1:0] n_w_last;
    logic [ROW_W-1:0]  n_h_last;
    logic [WID_W-1:0]  cfg_wid;
    logic [HGT_W-1:0]  cfg_hgt;
    logic              geom_wr;

    // position
    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] n_col;
    logic [ROW_W-1:0]  n_row;

    // handshake chain
    logic out_ready, c_ready, w_ready, a_ready;
    logic a_move, w_move, c_move, in_acc;

    // read stage
    logic              r_a_valid;
    logic [PIX_W-1:0]  r_a_px;
    logic [ADDR_W-1:0] r_a_addr;
    logic              r_a_emit;
    t_meta             r_a_meta;
    t_meta             n_a_meta;
    logic [2*PIX_W-1:0] rd_data;

    // window stage
    logic      r_w_valid;
    t_meta     r_w_meta;
    t_col_pix  cell_in  [WIN];
    t_col_pix  cell_pix [WIN];
    t_col_stat cell_stat [WIN];

    // combine stage
    logic                 r_c_valid;
    t_meta                r_c_meta;
    logic [WIN_SUM_W-1:0] r_c_sum;
    logic [PIX_W-1:0]     r_c_min;
    logic [PIX_W-1:0]     r_c_max;

    // output stage
    logic             r_o_valid;
    t_meta            r_o_meta;
    logic [PIX_W-1:0] r_o_value;
    logic [PROD_W-1:0] mean_prod;
    logic [PIX_W-1:0]  n_value;

    assign out_ready = !r_o_valid || !i_out_stall;
    assign c_ready   = !r_c_valid || out_ready;
    assign w_ready   = !r_w_valid || c_ready;
    assign a_ready   = !r_a_valid || w_ready;
    assign a_move    = r_a_valid && w_ready;
    assign w_move    = r_w_valid && c_ready;
    assign c_move    = r_c_valid && out_ready;
    assign in_acc    = i_in_valid && a_ready;
    assign o_in_stall = !a_ready;

    // geometry clamp on write
    assign cfg_wid = i_cfg_data[WID_W-1:0];
    assign cfg_hgt = i_cfg_data[HGT_W-1:0];
    assign geom_wr = i_cfg_we && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT);

    always_comb begin
        if (32'(cfg_wid) < 32'(SIZE_MIN)) begin
            n_w_last = ADDR_W'(SIZE_MIN - 1);
        end else if (32'(cfg_wid) > 32'(MAX_WIDTH)) begin
            n_w_last = ADDR_W'(MAX_WIDTH - 1);
        end else begin
            n_w_last = ADDR_W'(cfg_wid - WID_W'(1));
        end
        if (32'(cfg_hgt) < 32'(SIZE_MIN)) begin
            n_h_last = ROW_W'(SIZE_MIN - 1);
        end else if (32'(cfg_hgt) > 32'(HEIGHT_LIMIT)) begin
            n_h_last = ROW_W'(HEIGHT_LIMIT - 1);
        end else begin
            n_h_last = ROW_W'(cfg_hgt - HGT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= ADDR_W'(RESET_WIDTH - 1);
            r_h_last <= ROW_W'(RESET_HEIGHT - 1);
            r_mode   <= MODE_MEAN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_w_last <= n_w_last;
                REG_HEIGHT: r_h_last <= n_h_last;
                REG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                default:    ;
            endcase
        end
    end

    // raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (geom_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc) begin
            if (r_col == r_w_last) begin
                n_col = '0;
                n_row = (r_row == r_h_last) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // read stage
    always_comb begin
        n_a_meta.row  = r_row - 1'b1;
        n_a_meta.col  = COL_W'(r_col - 1'b1);
        n_a_meta.last = (r_row == r_h_last) && (r_col == r_w_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_px   <= i_pixel;
            r_a_addr <= r_col;
            r_a_emit <= (r_row >= ROW_W'(2)) && (r_col >= ADDR_W'(2));
            r_a_meta <= n_a_meta;
        end
    end

    wmmf_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (a_move),
        .i_wr_addr (r_a_addr),
        .i_wr_data ({rd_data[PIX_W-1:0], r_a_px})
    );

    // window: newest column enters cell 0 and moves along the row
    assign cell_in[0] = '{top: rd_data[2*PIX_W-1:PIX_W], mid: rd_data[PIX_W-1:0], bot: r_a_px};

    for (genvar g = 0; g < WIN; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign cell_in[g] = cell_pix[g-1];
        end
        wmmf_col_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (a_move),
            .i_pix  (cell_in[g]),
            .o_pix  (cell_pix[g]),
            .o_stat (cell_stat[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (a_move) begin
            r_w_valid <= r_a_emit;
        end else if (w_move) begin
            r_w_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_w_meta <= r_a_meta;
        end
    end

    // combine stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_move) begin
            r_c_valid <= 1'b1;
        end else if (c_move) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_c_meta <= r_w_meta;
            r_c_sum  <= WIN_SUM_W'(cell_stat[0].sum) + WIN_SUM_W'(cell_stat[1].sum)
                      + WIN_SUM_W'(cell_stat[2].sum);
            r_c_min  <= min3(cell_stat[0].min_v, cell_stat[1].min_v, cell_stat[2].min_v);
            r_c_max  <= max3(cell_stat[0].max_v, cell_stat[1].max_v, cell_stat[2].max_v);
        end
    end

    // output stage: sum / 9 as multiply by reciprocal
    assign mean_prod = PROD_W'(r_c_sum) * PROD_W'(RECIP_9);

    always_comb begin
        case (r_mode)
            MODE_MIN: n_value = r_c_min;
            MODE_MAX: n_value = r_c_max;
            default:  n_value = mean_prod[RECIP_SHIFT +: PIX_W];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (c_move) begin
            r_o_valid <= 1'b1;
        end else if (out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_move) begin
            r_o_meta  <= r_c_meta;
            r_o_value <= n_value;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_row   = r_o_meta.row;
    assign o_out_col   = r_o_meta.col;
    assign o_value     = r_o_value;
    assign o_last      = r_o_meta.last;

endmodule

`default_nettype wire

// ===== hw/rtl/wmmf_checker.sv =====
// wmmf_checker: port-level checks of the 3x3 window filter, bound to its top level
// uses only the top level's ports

`timescale 1ns / 1ps
`default_nettype none

module wmmf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_stall,
    input wire logic        i_out_valid,
    input wire logic        i_out_stall,
    input wire logic [11:0] i_out_row,
    input wire logic [10:0] i_out_col,
    input wire logic [7:0]  i_value,
    input wire logic        i_last
);

    // a stalled output word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("output word dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_row) && $stable(i_out_col)
            && $stable(i_value) && $stable(i_last))
        else $error("output word changed under stall");

    // input backs up only behind a blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid && i_out_stall)
        else $error("input stalled while output free");

    // words follow the raster order of centres
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_stall && !i_last |=> !i_out_valid
            || (i_out_row == $past(i_out_row) && i_out_col == $past(i_out_col) + 11'd1)
            || (i_out_row == $past(i_out_row) + 12'd1 && i_out_col == 11'd1))
        else $error("output word out of raster order");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_stall && i_last |=> !i_out_valid
            || (i_out_row == 12'd1 && i_out_col == 11'd1))
        else $error("frame did not restart at first centre");

endmodule

bind window_3x3_mean_min_max_filter wmmf_checker u_wmmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_row   (o_out_row),
    .i_out_col   (o_out_col),
    .i_value     (o_value),
    .i_last      (o_last)
);

`default_nettype wire
